// File: hw/rtl/bidirectional_binding_table_core_assert.svh
// Assertion macros for the binding table core.
`ifndef BIDIRECTIONAL_BINDING_TABLE_CORE_ASSERT_SVH
`define BIDIRECTIONAL_BINDING_TABLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BBT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBT_ASSERT(lbl, prop, msg)
`define BBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/bbt_pkg.sv
// Types and constants shared by the binding table core and its cells.
package bbt_pkg;

	localparam int TableDepth = 16;
	localparam int MacW       = 64;
	localparam int EpW        = 8;

	typedef enum logic [1:0] {
		OP_UPDATE     = 2'd0,
		OP_LOOKUP_SRC = 2'd1,
		OP_LOOKUP_DST = 2'd2,
		OP_LOOKUP_ID  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DST_REPLACED = 2'd0,
		ST_SRC_REPLACED = 2'd1,
		ST_INSERTED     = 2'd2,
		ST_INSERTED_DROP = 2'd3
	} status_t;

	typedef struct packed {
		op_t             op;
		logic [MacW-1:0] mac_a;
		logic [EpW-1:0]  ep_a;
		logic [MacW-1:0] mac_b;
		logic [EpW-1:0]  ep_b;
	} req_t;

	typedef struct packed {
		logic [MacW-1:0] src_mac;
		logic [EpW-1:0]  src_ep;
		logic [MacW-1:0] dst_mac;
		logic [EpW-1:0]  dst_ep;
	} entry_t;

	// Priority chain passed from the newest cell toward the oldest.
	typedef struct packed {
		logic            hit;
		logic            src_side;
		logic [MacW-1:0] mac;
		logic [EpW-1:0]  ep;
	} chain_t;

endpackage

// File: hw/rtl/bbt_cell.sv
// One table row: holds a binding, compares it with the request and joins the priority chain.
module bbt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  bbt_pkg::req_t   req,
	input  logic           cmp_en,
	input  logic           apply_en,
	input  logic           ins,
	input  bbt_pkg::entry_t nb_ent,
	input  logic           nb_vld,
	input  bbt_pkg::chain_t chain_in,
	output bbt_pkg::chain_t chain_out,
	output bbt_pkg::entry_t ent,
	output logic           vld
);
	import bbt_pkg::*;

	entry_t ent_q;
	logic   vld_q;
	logic   m_src_s2, m_dst_s2, m_ida_s2, m_idb_s2;
	logic   hit, win;
	logic [MacW-1:0] own_mac;
	logic [EpW-1:0]  own_ep;

	assign ent = ent_q;
	assign vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (apply_en && ins) begin
			vld_q <= nb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			m_src_s2 <= vld_q && ent_q.src_mac == req.mac_a && ent_q.src_ep == req.ep_a;
			m_dst_s2 <= vld_q && ent_q.dst_mac == req.mac_b && ent_q.dst_ep == req.ep_b;
			m_ida_s2 <= vld_q && ent_q.src_mac == req.mac_a;
			m_idb_s2 <= vld_q && ent_q.dst_mac == req.mac_a;
		end
	end

	always_comb begin
		hit     = 1'b0;
		own_mac = '0;
		own_ep  = '0;
		case (req.op)
			OP_UPDATE: begin
				hit = m_src_s2 | m_dst_s2;
			end
			OP_LOOKUP_SRC: begin
				hit     = m_src_s2;
				own_mac = ent_q.dst_mac;
				own_ep  = ent_q.dst_ep;
			end
			OP_LOOKUP_DST: begin
				hit     = m_dst_s2;
				own_mac = ent_q.src_mac;
				own_ep  = ent_q.src_ep;
			end
			OP_LOOKUP_ID: begin
				hit     = m_ida_s2 | m_idb_s2;
				own_mac = m_ida_s2 ? ent_q.dst_mac : ent_q.src_mac;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		win = hit & ~chain_in.hit;
		chain_out.hit      = chain_in.hit | hit;
		chain_out.src_side = win ? m_src_s2 : chain_in.src_side;
		chain_out.mac      = win ? own_mac : chain_in.mac;
		chain_out.ep       = win ? own_ep : chain_in.ep;
	end

	// On insert take the neighbor's row; otherwise, on an update, the winning row edits one side.
	always_ff @(posedge clk) begin
		if (apply_en) begin
			if (ins) begin
				ent_q <= nb_ent;
			end else if (win && req.op == OP_UPDATE) begin
				if (m_src_s2) begin
					ent_q.dst_mac <= req.mac_b;
					ent_q.dst_ep  <= req.ep_b;
				end else begin
					ent_q.src_mac <= req.mac_a;
					ent_q.src_ep  <= req.ep_a;
				end
			end
		end
	end

endmodule

// File: hw/rtl/bidirectional_binding_table_core.sv
// Top level of the bidirectional binding table: request register, row of cells, result register.
//
// Usage: drive operation, mac_a, ep_a, mac_b, ep_b and raise start; the request
// is taken at a clock edge where start is high and busy is low. busy stays high
// while the transaction is worked on, and no new request is taken then.
// Every transaction gives exactly one result: found, result_mac, result_ep and
// update_status are valid for the single cycle in which done is high.
// Steps: a taken request is held in the request register; every row then
// registers its compares, and next the priority chain resolves through the row
// of cells, the table updates and the result registers load; done rises with
// the result registers, when busy is already low, so a new request is taken
// only after the transaction is through.
// Updates search from the newest row; an insert shifts every row one cell
// toward the oldest, which drops out when the table is full.
// Reset empties the table (all row valid bits clear) and drops any transaction
// in flight. The receiver cannot stall: results are not held.
module bidirectional_binding_table_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [63:0]          mac_a,
	input  logic [7:0]           ep_a,
	input  logic [63:0]          mac_b,
	input  logic [7:0]           ep_b,
	output logic                 done,
	output logic                 found,
	output logic [63:0]          result_mac,
	output logic [7:0]           result_ep,
	output logic [1:0]           update_status
);
	import bbt_pkg::*;

	req_t   req_q;
	logic   v_s1_q, v_s2_q, done_q;
	logic   found_q;
	logic [MacW-1:0] mac_q;
	logic [EpW-1:0]  ep_q;
	status_t status_q;
	logic   accept, ins;
	entry_t req_ent;
	chain_t chain_w [TableDepth+1];
	entry_t ent_w [TableDepth];
	logic [TableDepth-1:0] vld_w;

	assign accept = start && !busy;
	assign busy   = v_s1_q || v_s2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q;
			done_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op    <= op_t'(operation);
			req_q.mac_a <= mac_a;
			req_q.ep_a  <= ep_a;
			req_q.mac_b <= mac_b;
			req_q.ep_b  <= ep_b;
		end
	end

	assign req_ent.src_mac = req_q.mac_a;
	assign req_ent.src_ep  = req_q.ep_a;
	assign req_ent.dst_mac = req_q.mac_b;
	assign req_ent.dst_ep  = req_q.ep_b;

	assign chain_w[0] = '0;
	assign ins = req_q.op == OP_UPDATE && !chain_w[TableDepth].hit;

	for (genvar i = 0; i < TableDepth; i++) begin : g_row
		bbt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_q),
			.cmp_en   (v_s1_q),
			.apply_en (v_s2_q),
			.ins      (ins),
			.nb_ent   ((i == 0) ? req_ent : ent_w[(i == 0) ? 0 : i-1]),
			.nb_vld   ((i == 0) ? 1'b1 : vld_w[(i == 0) ? 0 : i-1]),
			.chain_in (chain_w[i]),
			.chain_out(chain_w[i+1]),
			.ent      (ent_w[i]),
			.vld      (vld_w[i])
		);
	end

	always_ff @(posedge clk) begin
		if (v_s2_q) begin
			found_q <= req_q.op != OP_UPDATE && chain_w[TableDepth].hit;
			mac_q   <= chain_w[TableDepth].mac;
			ep_q    <= chain_w[TableDepth].ep;
			if (req_q.op != OP_UPDATE) begin
				status_q <= ST_DST_REPLACED;
			end else if (chain_w[TableDepth].hit) begin
				status_q <= chain_w[TableDepth].src_side ? ST_DST_REPLACED : ST_SRC_REPLACED;
			end else begin
				status_q <= vld_w[TableDepth-1] ? ST_INSERTED_DROP : ST_INSERTED;
			end
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign result_mac    = mac_q;
	assign result_ep     = ep_q;
	assign update_status = status_q;

`include "bidirectional_binding_table_core_assert.svh"

	`BBT_ASSERT(a_take_sets_busy, accept |=> busy, "accepted request did not raise busy")
	`BBT_ASSERT(a_done_after_work, done |-> $past(v_s2_q) && !busy, "result strobe out of step")
	`BBT_ASSERT(a_miss_is_zero, done && !found |-> result_mac == '0 && result_ep == '0, "miss carries data")
	`BBT_ASSERT(a_rows_packed, (vld_w & (vld_w + 1'b1)) == '0, "valid rows not packed at the front")

endmodule
